// File: src/particle_fall_or_spread_update_defines.svh
// Assertion macros for the particle update block.
// Included by the top level; relies on clk and rst in the including scope.
`ifndef PARTICLE_FALL_OR_SPREAD_UPDATE_DEFINES_SVH
`define PARTICLE_FALL_OR_SPREAD_UPDATE_DEFINES_SVH

// checked only out of reset
`define PFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/pfs_pkg.sv
// Shared types and constants of the particle update block.
// No dependencies.
package pfs_pkg;

  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_LOOP    = 3'd1;
  localparam logic [2:0] CFG_PIVOT_X = 3'd2;
  localparam logic [2:0] CFG_PIVOT_Y = 3'd3;
  localparam logic [2:0] CFG_PIVOT_Z = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic [30:0]        speed;
    logic [30:0]        age;
    logic [30:0]        life;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DIST, S_VEC, S_FALL, S_SQ, S_ROOT,
    S_DIV, S_MLO, S_MHI, S_MOV, S_AGE, S_FIN
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) return -32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

// File: src/pfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/particle_fall_or_spread_update.sv
// Top level of the particle update block: sequencer, shared multiplier, root and divide steps.
// Depends on pfs_pkg, pfs_ram and particle_fall_or_spread_update_defines.svh.
//
// One item at a time. A load, or an item whose index is past the table, goes
// straight to the result state. A tick in fall mode moves only the y position.
// A tick in spread mode reads the entry and forms the step distance (S_READ,
// S_DIST, S_VEC), sums the squared length in S_SQ, takes 32 steps of the
// bit-serial square root, then per axis 31 steps of the restoring divider,
// 2 multiplier passes and a move step, and ends with the age update, the
// result and the return to idle. A particle sitting on the pivot skips the axis
// work. All multiplications go through one shared 32x32 multiplier.
// The table is one RAM with a registered read port; unwritten entries read
// undefined. in_stall is high while an item is in work; a finished result waits
// in the output register while the next item is taken.
`include "particle_fall_or_spread_update_defines.svh"
module particle_fall_or_spread_update #(
  parameter int NUM_PARTICLES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [7:0]         index,
  input  logic signed [31:0] load_x,
  input  logic signed [31:0] load_y,
  input  logic signed [31:0] load_z,
  input  logic [30:0]        load_speed,
  input  logic [30:0]        load_lifetime,
  input  logic [23:0]        time_delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [30:0]        age,
  output logic               restarted,
  output logic               expired
);
  import pfs_pkg::*;

  localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

  // configuration
  logic mode, loop_en;
  logic signed [31:0] pivot [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      loop_en <= 1'b0;
      pivot[0] <= '0;
      pivot[1] <= '0;
      pivot[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    mode <= cfg_data[0];
        CFG_LOOP:    loop_en <= cfg_data[0];
        CFG_PIVOT_X: pivot[0] <= cfg_data;
        CFG_PIVOT_Y: pivot[1] <= cfg_data;
        CFG_PIVOT_Z: pivot[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic accept, idx_ok;
  assign accept = in_valid && !in_stall;
  assign idx_ok = (32'(index) < NUM_PARTICLES);

  // working registers
  logic [AW-1:0]      addr;
  logic signed [31:0] wc [3];
  logic signed [31:0] ws [3];
  logic [30:0]        spd, life, agev;
  logic [23:0]        td;
  logic [30:0]        av [3];
  logic               neg [3];
  logic [38:0]        dstep;
  logic [63:0]        acc, rs, rr, prod;
  logic [4:0]         cnt;
  logic [1:0]         axis;
  logic [31:0]        len;
  logic [32:0]        rem;
  logic [30:0]        q;
  logic [30:0]        mlo;
  logic signed [31:0] res_x, res_y, res_z;
  logic [30:0]        res_age;
  logic               res_rs, res_ex;

  // table
  entry_t ram_wdata, ram_rdata, ld_entry;
  logic   ram_we;
  logic [AW-1:0] ram_addr;
  assign ram_addr = accept ? AW'(index) : addr;

  assign ld_entry = '{cx: load_x, cy: load_y, cz: load_z, sx: load_x, sy: load_y,
                      sz: load_z, speed: load_speed, age: 31'd0, life: load_lifetime};

  pfs_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUM_PARTICLES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DIST: begin
        mul_a = 32'(spd);
        mul_b = 32'(td);
      end
      S_SQ: begin
        case (cnt[1:0])
          2'd0: begin mul_a = 32'(av[0]); mul_b = 32'(av[0]); end
          2'd1: begin mul_a = 32'(av[1]); mul_b = 32'(av[1]); end
          default: begin mul_a = 32'(av[2]); mul_b = 32'(av[2]); end
        endcase
      end
      S_MLO: begin
        mul_a = 32'(dstep[29:0]);
        mul_b = 32'(q);
      end
      S_MHI: begin
        mul_a = 32'(dstep[38:30]);
        mul_b = 32'(q);
      end
      default: ;
    endcase
  end

  // vector from pivot, magnitude per axis
  logic signed [32:0] vdiff [3];
  logic [32:0]        vmag [3];
  logic               big;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vdiff[k] = {wc[k][31], wc[k]} - {pivot[k][31], pivot[k]};
      vmag[k]  = vdiff[k][32] ? 33'(-vdiff[k]) : 33'(vdiff[k]);
    end
    big = (vmag[0][32:31] != 2'b00) || (vmag[1][32:31] != 2'b00) ||
          (vmag[2][32:31] != 2'b00);
  end

  // square root step
  logic [63:0] rbit, rtmp, rs_step, rr_step;
  always_comb begin
    rbit = 64'd1 << {cnt, 1'b0};
    rtmp = rr + rbit;
    if (rs >= rtmp) begin
      rs_step = rs - rtmp;
      rr_step = (rr >> 1) + rbit;
    end else begin
      rs_step = rs;
      rr_step = rr >> 1;
    end
  end

  // divide step
  logic [32:0] dnum, ddiff;
  logic        dbit;
  always_comb begin
    dnum  = (cnt == 5'd0) ? {2'b00, av[axis]} : rem;
    dbit  = (dnum >= {1'b0, len});
    ddiff = dbit ? (dnum - {1'b0, len}) : dnum;
  end

  // axis move
  logic [40:0]        mv;
  logic signed [47:0] mv_sum, fall_sum;
  assign mv       = 41'(prod[40:0]) + 41'(mlo);
  assign mv_sum   = neg[axis] ? (48'(wc[axis]) - $signed({7'd0, mv}))
                              : (48'(wc[axis]) + $signed({7'd0, mv}));
  assign fall_sum = 48'(wc[1]) - $signed({9'd0, dstep});

  // age update
  logic [31:0] age_sum;
  logic [30:0] age_sat;
  logic        reached;
  assign age_sum = 32'(agev) + 32'(td);
  assign age_sat = age_sum[31] ? 31'h7FFF_FFFF : age_sum[30:0];
  assign reached = (age_sat >= life);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = (idx_ok && op == OP_TICK) ? S_READ : S_FIN;
      S_READ: state_next = S_DIST;
      S_DIST: state_next = S_VEC;
      S_VEC:  state_next = mode ? S_SQ : S_FALL;
      S_FALL: state_next = S_AGE;
      S_SQ:   if (cnt == 5'd3) state_next = S_ROOT;
      S_ROOT: if (cnt == 5'd0) state_next = (rr_step == 64'd0) ? S_AGE : S_DIV;
      S_DIV:  if (cnt == 5'd30) state_next = S_MLO;
      S_MLO:  state_next = S_MHI;
      S_MHI:  state_next = S_MOV;
      S_MOV:  state_next = (axis == 2'd2) ? S_AGE : S_DIV;
      S_AGE:  state_next = S_FIN;
      S_FIN:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = (state != S_IDLE);
    ram_we    = 1'b0;
    ram_wdata = ld_entry;
    unique case (state)
      S_IDLE: ram_we = accept && idx_ok && (op == OP_LOAD);
      S_AGE: begin
        ram_we = 1'b1;
        ram_wdata = '{cx: (reached && loop_en) ? ws[0] : wc[0],
                      cy: (reached && loop_en) ? ws[1] : wc[1],
                      cz: (reached && loop_en) ? ws[2] : wc[2],
                      sx: ws[0], sy: ws[1], sz: ws[2], speed: spd,
                      age: (reached && loop_en) ? 31'd0 : age_sat, life: life};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || !out_stall)) begin
      pos_x <= res_x;
      pos_y <= res_y;
      pos_z <= res_z;
      age <= res_age;
      restarted <= res_rs;
      expired <= res_ex;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    unique case (state)
      S_IDLE: if (accept) begin
        addr <= AW'(index);
        td <= time_delta;
        res_rs <= 1'b0;
        res_ex <= 1'b0;
        res_age <= '0;
        if (idx_ok) begin
          res_x <= load_x;
          res_y <= load_y;
          res_z <= load_z;
        end else begin
          res_x <= '0;
          res_y <= '0;
          res_z <= '0;
        end
      end
      S_READ: begin
        wc[0] <= ram_rdata.cx;
        wc[1] <= ram_rdata.cy;
        wc[2] <= ram_rdata.cz;
        ws[0] <= ram_rdata.sx;
        ws[1] <= ram_rdata.sy;
        ws[2] <= ram_rdata.sz;
        spd <= ram_rdata.speed;
        agev <= ram_rdata.age;
        life <= ram_rdata.life;
      end
      S_VEC: begin
        dstep <= prod[54:16];
        cnt <= '0;
        for (int k = 0; k < 3; k++) begin
          neg[k] <= vdiff[k][32];
          av[k] <= big ? vmag[k][31:1] : vmag[k][30:0];
        end
      end
      S_FALL: wc[1] <= sat32(fall_sum);
      S_SQ: begin
        case (cnt[1:0])
          2'd0: ;
          2'd1: acc <= prod;
          2'd2: acc <= acc + prod;
          default: begin
            rs <= acc + prod;
            rr <= '0;
          end
        endcase
        cnt <= (cnt == 5'd3) ? 5'd31 : cnt + 5'd1;
      end
      S_ROOT: begin
        rs <= rs_step;
        rr <= rr_step;
        len <= rr_step[31:0];
        axis <= '0;
        cnt <= (cnt == 5'd0) ? 5'd0 : cnt - 5'd1;
      end
      S_DIV: begin
        rem <= {ddiff[31:0], 1'b0};
        q <= {q[29:0], dbit};
        cnt <= (cnt == 5'd30) ? 5'd0 : cnt + 5'd1;
      end
      S_MHI: mlo <= prod[60:30];
      S_MOV: begin
        wc[axis] <= sat32(mv_sum);
        axis <= axis + 2'd1;
      end
      S_AGE: begin
        res_x <= ram_wdata.cx;
        res_y <= ram_wdata.cy;
        res_z <= ram_wdata.cz;
        res_age <= ram_wdata.age;
        res_rs <= reached && loop_en;
        res_ex <= reached && !loop_en;
      end
      default: ;
    endcase
  end

  `PFS_ASSERT(a_busy_stalls, (state != S_IDLE) |-> in_stall, "input taken while busy")
  `PFS_ASSERT(a_accept_leaves_idle, accept |=> (state != S_IDLE), "accepted item lost")
  `PFS_ASSERT(a_flags_exclusive, out_valid |-> !(restarted && expired),
              "restart and expiry together")
  `PFS_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !out_valid),
                     "reset did not clear sequencer")
endmodule

// File: tb/tb_top.sv
// Self-checking bench for particle_fall_or_spread_update: random and directed load/tick items,
// predicted in-bench and compared field by field. Depends on pfs_pkg and the block's RTL.
module tb_top;
  import pfs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic               op;
    logic [7:0]         index;
    logic signed [31:0] lx, ly, lz;
    logic [30:0]        speed, life;
    logic [23:0]        td;
  } particle_cmd_t;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic [30:0]        age;
    logic               restarted, expired;
  } particle_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_MODE;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_LOAD;
  logic [7:0] index = '0;
  logic signed [31:0] load_x = '0, load_y = '0, load_z = '0;
  logic [30:0] load_speed = '0, load_lifetime = '0;
  logic [23:0] time_delta = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [30:0] age;
  logic restarted, expired;

  particle_fall_or_spread_update u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the block's registers and particle table
  logic               sh_mode, sh_loop;
  logic signed [31:0] sh_pivot [3];
  logic signed [31:0] tab_cur [256][3];
  logic signed [31:0] tab_start [256][3];
  logic [30:0]        tab_speed [256], tab_age [256], tab_life [256];

  particle_cmd_t   pending_cmds[$];
  particle_state_t expected_states[$];
  particle_cmd_t   cmd_on_bus;
  bit              quiet = 0;
  int              mismatches = 0;
  int              results_seen = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // move one axis by d along the unit component a/len, away from the pivot
  function automatic logic signed [31:0] push_axis(input logic signed [31:0] c, input longint v,
      input longint unsigned a, input longint unsigned len, input longint unsigned d);
    longint unsigned u, m;
    u = (a << 30) / len;
    m = (d >> 30) * u + (((d & 64'h3FFF_FFFF) * u) >> 30);
    return clamp32(v < 0 ? longint'(c) - longint'(m) : longint'(c) + longint'(m));
  endfunction

  task automatic update_particle(input particle_cmd_t c);
    particle_state_t r;
    longint v [3];
    longint unsigned a [3];
    longint unsigned d, len, new_age;
    int i;
    i = c.index;
    r.restarted = 1'b0;
    r.expired = 1'b0;
    if (c.op == OP_LOAD) begin
      tab_cur[i][0] = c.lx; tab_cur[i][1] = c.ly; tab_cur[i][2] = c.lz;
      tab_start[i] = tab_cur[i];
      tab_speed[i] = c.speed;
      tab_life[i] = c.life;
      tab_age[i] = '0;
    end else begin
      d = (longint'(tab_speed[i]) * longint'(c.td)) >> 16;
      if (!sh_mode) begin
        tab_cur[i][1] = clamp32(longint'(tab_cur[i][1]) - longint'(d));
      end else begin
        for (int k = 0; k < 3; k++) begin
          v[k] = longint'(tab_cur[i][k]) - longint'(sh_pivot[k]);
          a[k] = v[k] < 0 ? -v[k] : v[k];
        end
        if (a[0] >= 64'h8000_0000 || a[1] >= 64'h8000_0000 || a[2] >= 64'h8000_0000)
          for (int k = 0; k < 3; k++) a[k] = a[k] >> 1;
        len = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        if (len != 0)
          for (int k = 0; k < 3; k++)
            tab_cur[i][k] = push_axis(tab_cur[i][k], v[k], a[k], len, d);
      end
      new_age = longint'(tab_age[i]) + longint'(c.td);
      if (new_age > 64'h7FFF_FFFF) new_age = 64'h7FFF_FFFF;
      if (new_age >= longint'(tab_life[i])) begin
        if (sh_loop) begin
          new_age = 0;
          tab_cur[i] = tab_start[i];
          r.restarted = 1'b1;
        end else begin
          r.expired = 1'b1;
        end
      end
      tab_age[i] = new_age[30:0];
    end
    r.px = tab_cur[i][0];
    r.py = tab_cur[i][1];
    r.pz = tab_cur[i][2];
    r.age = tab_age[i];
    expected_states.push_back(r);
  endtask

  // sender
  int send_gap = 0;
  always @(posedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (!rst) begin
      if (in_valid && !in_stall) update_particle(cmd_on_bus);
      if (!(in_valid && in_stall)) begin
        next_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_cmds.size() > 0) begin
          cmd_on_bus = pending_cmds.pop_front();
          op <= cmd_on_bus.op;
          index <= cmd_on_bus.index;
          load_x <= cmd_on_bus.lx;
          load_y <= cmd_on_bus.ly;
          load_z <= cmd_on_bus.lz;
          load_speed <= cmd_on_bus.speed;
          load_lifetime <= cmd_on_bus.life;
          time_delta <= cmd_on_bus.td;
          next_valid = 1'b1;
          send_gap <= pick_gap();
        end
      end
    end
    in_valid <= next_valid;
  end

  // receiver stall, with one long hold-off once traffic is flowing
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 100) begin
      hold_done <= 1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    particle_state_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_states.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result item at %0t", $realtime);
      end else begin
        e = expected_states.pop_front();
        if (pos_x !== e.px || pos_y !== e.py || pos_z !== e.pz || age !== e.age ||
            restarted !== e.restarted || expired !== e.expired) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: got pos %h %h %h age %h rs %b ex %b, exp %h %h %h %h %b %b",
                     $realtime, pos_x, pos_y, pos_z, age, restarted, expired,
                     e.px, e.py, e.pz, e.age, e.restarted, e.expired);
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  bit loaded [256];

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(input logic o, input logic [7:0] i, input logic [31:0] x, y, z,
                           input logic [30:0] s, l, input logic [23:0] t);
    particle_cmd_t c;
    c.op = o; c.index = i; c.lx = x; c.ly = y; c.lz = z; c.speed = s; c.life = l; c.td = t;
    if (o == OP_LOAD) loaded[i] = 1;
    pending_cmds.push_back(c);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MODE:    sh_mode = val[0];
      CFG_LOOP:    sh_loop = val[0];
      CFG_PIVOT_X: sh_pivot[0] = val;
      CFG_PIVOT_Y: sh_pivot[1] = val;
      CFG_PIVOT_Z: sh_pivot[2] = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_cmd();
    logic [7:0]  i;
    logic [30:0] s, l;
    logic [23:0] t;
    i = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    s = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0008_0000));
    l = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0010_0000));
    t = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 32'h0004_0000));
    if (!loaded[i] || $urandom_range(0, 4) == 0)
      queue_cmd(OP_LOAD, i, rand_word(), rand_word(), rand_word(), s, l, t);
    else
      queue_cmd(OP_TICK, i, $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom), t);
  endtask

  initial begin
    sh_mode = 0;
    sh_loop = 0;
    sh_pivot = '{default: '0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // fall mode, no looping until the last tick: extremes, saturation, zero lifetime, expiry
    queue_cmd(OP_LOAD, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'h0);
    queue_cmd(OP_TICK, 8'd0, 0, 0, 0, 0, 0, 24'hFF_FFFF);
    queue_cmd(OP_LOAD, 8'd255, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              31'h7FFF_FFFF, 31'h0, 24'hFF_FFFF);
    queue_cmd(OP_TICK, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFF_FFFF);
    queue_cmd(OP_TICK, 8'd255, 0, 0, 0, 0, 0, 24'h0);
    queue_cmd(OP_LOAD, 8'd1, 0, 0, 0, 31'h1_0000, 31'h3_0000, 24'h0);
    repeat (3) queue_cmd(OP_TICK, 8'd1, 0, 0, 0, 0, 0, 24'h1_0000);
    drain();
    write_reg(CFG_LOOP, 32'd1);
    queue_cmd(OP_TICK, 8'd1, 0, 0, 0, 0, 0, 24'h2_0000);
    drain();

    // spread mode around the origin: particle on the pivot, wide vector, looping
    write_reg(CFG_MODE, 32'd1);
    write_reg(CFG_PIVOT_X, 32'd0);
    write_reg(CFG_PIVOT_Y, 32'd0);
    write_reg(CFG_PIVOT_Z, 32'd0);
    queue_cmd(OP_LOAD, 8'd2, 0, 0, 0, 31'h1_0000, 31'h7FFF_FFFF, 24'h0);
    queue_cmd(OP_TICK, 8'd2, 0, 0, 0, 0, 0, 24'h1_0000);
    queue_cmd(OP_LOAD, 8'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'h0);
    queue_cmd(OP_TICK, 8'd3, 0, 0, 0, 0, 0, 24'hFF_FFFF);
    queue_cmd(OP_LOAD, 8'd4, 32'h1_0000, 32'h2_0000, -32'sh3_0000,
              31'h5_0000, 31'h2_0000, 24'h0);
    repeat (2) queue_cmd(OP_TICK, 8'd4, 0, 0, 0, 0, 0, 24'h1_0000);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_MODE, $urandom_range(0, 1));
      write_reg(CFG_LOOP, $urandom_range(0, 1));
      for (int k = 0; k < 3; k++)
        write_reg(3'(CFG_PIVOT_X + k),
                  ph == 0 ? 32'h7FFF_FFFF : ph == 1 ? 32'h8000_0000 : rand_word());
      quiet = (ph % 4 == 3);
      repeat (133) random_cmd();
      drain();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: particle_fall_or_spread_update.f
+incdir+src
src/pfs_pkg.sv
src/pfs_ram.sv
src/particle_fall_or_spread_update.sv
tb/tb_top.sv
